// File: design/touch_sample_poll_sequencer_macros.svh
// assertion helpers for the touch sample poll sequencer
`ifndef TOUCH_SAMPLE_POLL_SEQUENCER_MACROS_SVH
`define TOUCH_SAMPLE_POLL_SEQUENCER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TSPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsps assertion failed");

// next-cycle implication, checked out of reset
`define TSPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsps assertion failed");

`endif

// File: design/tsps_pkg.sv
package tsps_pkg;

   localparam int unsigned VALUE_W = 12;
   localparam int unsigned TAG_W   = 4;
   localparam int unsigned CMD_W   = 16;
   localparam int unsigned CNT_W   = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned CSR_W   = 12;

   localparam logic [TAG_W-1:0] TAG_X        = 4'd1;
   localparam logic [TAG_W-1:0] TAG_Y        = 4'd2;
   localparam logic [TAG_W-1:0] TAG_PRESSURE = 4'd7;

   localparam logic [CMD_W-1:0] CMD_DUMP_REQUEST = 16'd512;
   localparam logic [CMD_W-1:0] CMD_NOOP         = 16'd0;

   localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POSITION = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEN_UP   = 2'd2;

   localparam logic [CNT_W-1:0] CNT_CEILING = 8'd255;

   localparam logic [VALUE_W-1:0] MIN_COORD_RESET = 12'd50;
   localparam logic [VALUE_W-1:0] MIN_PRESS_RESET = 12'd500;
   localparam logic [CNT_W-1:0]   INV_LIMIT_RESET = 8'd10;

   typedef enum logic [1:0] {
      CSR_MIN_COORDINATE = 2'd0,
      CSR_MIN_PRESSURE   = 2'd1,
      CSR_INVALID_LIMIT  = 2'd2,
      CSR_ENABLED        = 2'd3
   } tsps_csr_index_type;

   typedef struct packed {
      logic [VALUE_W-1:0] min_coordinate;
      logic [VALUE_W-1:0] min_pressure;
      logic [CNT_W-1:0]   invalid_limit;
      logic               enabled;
   } tsps_cfg_type;

   typedef struct packed {
      logic        pen_level;
      logic [15:0] rx_word;
   } tsps_req_type;

   typedef struct packed {
      logic [CMD_W-1:0]   next_command;
      logic [KIND_W-1:0]  report_kind;
      logic               touch_start;
      logic [VALUE_W-1:0] pos_x;
      logic [VALUE_W-1:0] pos_y;
      logic [VALUE_W-1:0] pressure_out;
      logic               invalid_reset;
   } tsps_rsp_type;

endpackage

// File: design/tsps_csr.sv
module tsps_csr
   import tsps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [1:0]         wr_index,
   input  logic [CSR_W-1:0]   wr_data,
   output tsps_cfg_type       cfg
);

   tsps_cfg_type cfg_ff;
   tsps_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_MIN_COORDINATE: cfg_in.min_coordinate = wr_data[VALUE_W-1:0];
            CSR_MIN_PRESSURE:   cfg_in.min_pressure   = wr_data[VALUE_W-1:0];
            CSR_INVALID_LIMIT:  cfg_in.invalid_limit  = wr_data[CNT_W-1:0];
            CSR_ENABLED:        cfg_in.enabled        = wr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_coordinate <= MIN_COORD_RESET;
         cfg_ff.min_pressure   <= MIN_PRESS_RESET;
         cfg_ff.invalid_limit  <= INV_LIMIT_RESET;
         cfg_ff.enabled        <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/tsps_engine.sv
module tsps_engine
   import tsps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tsps_cfg_type cfg,
   input  logic         step,      // staged item moves to the result register
   input  tsps_req_type item,
   output tsps_rsp_type result
);

   logic               in_session_ff, in_session_in;
   logic               read_phase_ff, read_phase_in;
   logic [VALUE_W-1:0] held_x_ff, held_x_in;
   logic [VALUE_W-1:0] held_y_ff, held_y_in;
   logic [VALUE_W-1:0] held_p_ff, held_p_in;
   logic [CNT_W-1:0]   inv_cnt_ff, inv_cnt_in;
   logic               reported_ff, reported_in;

   logic [TAG_W-1:0]   tag;
   logic [VALUE_W-1:0] val;
   logic               new_session;
   logic               cur_read;
   logic [VALUE_W-1:0] cur_x, cur_y, cur_p;
   logic [CNT_W-1:0]   cur_cnt;

   assign tag = item.rx_word[15:12];
   assign val = item.rx_word[VALUE_W-1:0];

   // a fresh session starts from cleared holds and the request phase
   assign new_session = item.pen_level && !in_session_ff;
   assign cur_read    = new_session ? 1'b0 : read_phase_ff;
   assign cur_x       = new_session ? '0 : held_x_ff;
   assign cur_y       = new_session ? '0 : held_y_ff;
   assign cur_p       = new_session ? '0 : held_p_ff;
   assign cur_cnt     = new_session ? '0 : inv_cnt_ff;

   always_comb begin
      in_session_in = in_session_ff;
      read_phase_in = read_phase_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_p_in     = held_p_ff;
      inv_cnt_in    = inv_cnt_ff;
      reported_in   = reported_ff;
      result        = '0;

      if (cfg.enabled) begin
         if (item.pen_level) begin
            in_session_in = 1'b1;
            read_phase_in = cur_read;
            held_x_in     = cur_x;
            held_y_in     = cur_y;
            held_p_in     = cur_p;
            inv_cnt_in    = cur_cnt;
            if (!cur_read) begin
               read_phase_in = 1'b1;
            end else if (tag == TAG_X) begin
               inv_cnt_in = '0;
               held_x_in  = val;
            end else if (tag == TAG_Y) begin
               inv_cnt_in = '0;
               held_y_in  = val;
            end else if (tag == TAG_PRESSURE) begin
               inv_cnt_in    = '0;
               held_p_in     = val;
               read_phase_in = 1'b0;
               if (cur_x >= cfg.min_coordinate && cur_y >= cfg.min_coordinate &&
                   val >= cfg.min_pressure) begin
                  result.report_kind  = KIND_POSITION;
                  result.touch_start  = !reported_ff;
                  result.pos_x        = cur_x;
                  result.pos_y        = cur_y;
                  result.pressure_out = val;
                  reported_in         = 1'b1;
               end
            end else if (cur_cnt != CNT_CEILING) begin
               inv_cnt_in = cur_cnt + CNT_W'(1);
            end
            // limit check runs on every pen-down poll
            if (inv_cnt_in >= cfg.invalid_limit) begin
               inv_cnt_in           = '0;
               read_phase_in        = 1'b0;
               result.invalid_reset = 1'b1;
            end
         end else if (in_session_ff) begin
            in_session_in = 1'b0;
            if (reported_ff) begin
               result.report_kind = KIND_PEN_UP;
               reported_in        = 1'b0;
            end
         end
         result.next_command = (in_session_in && read_phase_in) ? CMD_NOOP
                                                                 : CMD_DUMP_REQUEST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_session_ff <= 1'b0;
         read_phase_ff <= 1'b0;
         held_x_ff     <= '0;
         held_y_ff     <= '0;
         held_p_ff     <= '0;
         inv_cnt_ff    <= '0;
         reported_ff   <= 1'b0;
      end else if (step) begin
         in_session_ff <= in_session_in;
         read_phase_ff <= read_phase_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         held_p_ff     <= held_p_in;
         inv_cnt_ff    <= inv_cnt_in;
         reported_ff   <= reported_in;
      end
   end

endmodule

// File: design/touch_sample_poll_sequencer.sv
// touch sample poll sequencer
// req channel: one transfer per poll tick, carrying the pen-down level and the
//   16-bit word returned by the touch controller (4-bit tag, 12-bit value)
// rsp channel: exactly one transfer per req transfer, in order: the command
//   word for the next poll plus any position or pen-up report
// csr channel: register writes (index 0 min coordinate, 1 min pressure,
//   2 invalid limit, 3 enable); always ready, to be used only while idle
// path: a req transfer is captured in the input register, then decoded into
//   the result register, which drives rsp
// throughput: one tick per cycle while rsp_ready is high; session state updates
//   in the same cycle the staged tick is decoded, so ticks chain without gaps
// stall: when rsp_ready is low the result register holds; the input register
//   still takes one more tick, then req_ready drops until rsp drains
// reset: synchronous, active high; empties both registers, returns the
//   session to idle/request phase and loads the register defaults
`include "touch_sample_poll_sequencer_macros.svh"

module touch_sample_poll_sequencer
   import tsps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // poll tick input
   input  logic               req_valid,
   output logic               req_ready,
   input  tsps_req_type       req_data,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tsps_rsp_type       rsp_data,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   tsps_cfg_type cfg;

   // input stage
   logic         stg_valid_ff, stg_valid_in;
   tsps_req_type stg_data_ff;

   // result stage
   logic         out_valid_ff, out_valid_in;
   tsps_rsp_type out_data_ff;
   tsps_rsp_type step_result;

   logic out_free;
   logic advance;
   logic req_xfer;

   // register writes never stall
   assign csr_ready = 1'b1;

   tsps_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // result register is free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = stg_valid_ff && out_free;
   assign req_ready = !stg_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   tsps_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (stg_data_ff),
      .result (step_result)
   );

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (req_xfer) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stg_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // a forced re-request always asks for a new dump
   `TSPS_ASSERT_NOW(a_inv_reset_dumps, clock, reset,
      rsp_valid && rsp_data.invalid_reset, rsp_data.next_command == CMD_DUMP_REQUEST)
   // pen-up report carries no position
   `TSPS_ASSERT_NOW(a_pen_up_clean, clock, reset,
      rsp_valid && rsp_data.report_kind == KIND_PEN_UP,
      rsp_data.pos_x == '0 && rsp_data.pos_y == '0 && rsp_data.pressure_out == '0)
   // touch start flag only rides on a position report
   `TSPS_ASSERT_NOW(a_start_on_position, clock, reset,
      rsp_valid && rsp_data.touch_start, rsp_data.report_kind == KIND_POSITION)
   // a staged tick blocked by a stalled result is still staged next cycle
   `TSPS_ASSERT_NEXT(a_stage_held, clock, reset,
      stg_valid_ff && out_valid_ff && !rsp_ready, stg_valid_ff)

endmodule
